// ===== src/ftpp_pkg.sv =====
// Package for the framed target packet parser: request and result structs,
// parser phase encoding, register indexes and reset values. No dependencies.
package ftpp_pkg;

    // Number of payload bytes in a "found" frame and width of one byte.
    localparam int unsigned PAYLOAD_LEN = 4;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned COORD_W     = 16;
    localparam int unsigned AGE_W       = 17;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_HEADER    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOUND_CMD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOST_CMD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRAIL1    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TRAIL2    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 3'd5;

    // Register reset values.
    localparam logic [BYTE_W-1:0]     RST_HEADER    = 8'hAA;
    localparam logic [BYTE_W-1:0]     RST_FOUND_CMD = 8'h01;
    localparam logic [BYTE_W-1:0]     RST_LOST_CMD  = 8'h00;
    localparam logic [BYTE_W-1:0]     RST_TRAIL1    = 8'h0D;
    localparam logic [BYTE_W-1:0]     RST_TRAIL2    = 8'h0A;
    localparam logic [CFG_DATA_W-1:0] RST_TIMEOUT   = 16'd500;

    // Input modes.
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_COMMAND = 3'd1,
        PH_PAYLOAD = 3'd2,
        PH_TRAIL1  = 3'd3,
        PH_TRAIL2  = 3'd4
    } t_phase;

    typedef struct packed {
        logic              mode;
        logic [BYTE_W-1:0] rx_byte;
    } t_in;

    typedef struct packed {
        logic               target_found;
        logic [COORD_W-1:0] target_x;
        logic [COORD_W-1:0] target_y;
        logic               frame_done;
        logic               timed_out;
    } t_out;

    // Frame-matching bytes handed to the parser.
    typedef struct packed {
        logic [BYTE_W-1:0] header;
        logic [BYTE_W-1:0] found_cmd;
        logic [BYTE_W-1:0] lost_cmd;
        logic [BYTE_W-1:0] trail1;
        logic [BYTE_W-1:0] trail2;
    } t_frame_cfg;

    // Completed-frame event reported by the parser for the current byte.
    typedef struct packed {
        logic               found_done;
        logic               lost_done;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_frame_evt;

endpackage

// ===== src/ftpp_parser.sv =====
// Byte-level frame parser: header, command, payload and trailer tracking.
// Depends on ftpp_pkg for the phase encoding and the config/event structs.
module ftpp_parser
    import ftpp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_byte_valid,
    input  logic [7:0]  i_byte,
    input  t_frame_cfg  i_cfg,
    output t_frame_evt  o_evt
);

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_cmd, n_cmd;
    logic [2:0]        r_count, n_count;
    logic [BYTE_W-1:0] r_payload [PAYLOAD_LEN];
    logic              payload_we;

    // Phase register and held command.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_cmd   <= '0;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            r_cmd   <= n_cmd;
            r_count <= n_count;
        end
    end

    // Payload bytes have no reset; they are written only in the payload phase.
    always_ff @(posedge i_clk) begin
        if (payload_we) begin
            r_payload[r_count[1:0]] <= i_byte;
        end
    end

    // Next phase and frame completion for the byte now being taken.
    always_comb begin
        n_phase          = r_phase;
        n_cmd            = r_cmd;
        n_count          = r_count;
        payload_we       = 1'b0;
        o_evt.found_done = 1'b0;
        o_evt.lost_done  = 1'b0;
        o_evt.x          = {r_payload[1], r_payload[0]};
        o_evt.y          = {r_payload[3], r_payload[2]};
        if (i_byte_valid) begin
            case (r_phase)
                PH_COMMAND: begin
                    n_cmd = i_byte;
                    if (i_byte == i_cfg.found_cmd) begin
                        n_count = '0;
                        n_phase = PH_PAYLOAD;
                    end else if (i_byte == i_cfg.lost_cmd) begin
                        n_phase = PH_TRAIL1;
                    end else begin
                        n_phase = PH_HEADER;
                    end
                end
                PH_PAYLOAD: begin
                    payload_we = 1'b1;
                    n_count    = r_count + 3'd1;
                    if (n_count >= 3'(PAYLOAD_LEN)) begin
                        n_phase = PH_TRAIL1;
                    end
                end
                PH_TRAIL1: begin
                    n_phase = (i_byte == i_cfg.trail1) ? PH_TRAIL2 : PH_HEADER;
                end
                PH_TRAIL2: begin
                    // The held command is checked against the registers as they are now.
                    if (i_byte == i_cfg.trail2) begin
                        if (r_cmd == i_cfg.found_cmd) begin
                            o_evt.found_done = 1'b1;
                        end else if (r_cmd == i_cfg.lost_cmd) begin
                            o_evt.lost_done = 1'b1;
                        end
                    end
                    n_phase = PH_HEADER;
                end
                default: begin
                    n_phase = (i_byte == i_cfg.header) ? PH_COMMAND : PH_HEADER;
                end
            endcase
        end
    end

    // While collecting payload the count never reaches the frame length.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_count < 3'(PAYLOAD_LEN))
        else $error("payload count out of range");

    // A completed frame always sends the parser back to the header hunt.
    a_done_to_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_evt.found_done || o_evt.lost_done) |=> r_phase == PH_HEADER)
        else $error("parser did not return to header after a frame");

endmodule

// ===== src/framed_target_packet_parser.sv =====
// Top level of the framed target packet parser: config registers, found flag,
// age counter and the two-entry result buffer. Depends on ftpp_pkg, ftpp_parser.
//
// Each request is either a received byte or a timer tick, and each one yields
// exactly one result. That result is in the output register on the cycle after
// the request is accepted, unless an earlier result is still waiting for the
// receiver. The block takes one request per clock cycle; all per-request work
// is a single pass of logic whose state is updated at acceptance. Results go
// into an output register backed by a one-entry skid register, so a request is
// still accepted while one finished result waits; o_in_ready drops only when
// both are full. Configuration is written through i_cfg_we/i_cfg_index/i_cfg_data
// with no wait; indexes beyond the last register are ignored.
module framed_target_packet_parser
    import ftpp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [AGE_W-1:0] AGE_MAX = '1;

    t_frame_cfg          r_cfg;
    logic [CFG_DATA_W-1:0] r_timeout;
    logic                r_found, n_found;
    logic [COORD_W-1:0]  r_x, n_x;
    logic [COORD_W-1:0]  r_y, n_y;
    logic [AGE_W-1:0]    r_age, n_age;
    logic                r_out_valid, r_skid_valid;
    t_out                r_out, r_skid;
    t_out                result;
    t_frame_evt          evt;
    logic                in_fire, out_free, byte_valid, expired;

    assign o_in_ready  = !r_skid_valid;
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign byte_valid  = in_fire && (i_in_data.mode == MODE_BYTE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header    <= RST_HEADER;
            r_cfg.found_cmd <= RST_FOUND_CMD;
            r_cfg.lost_cmd  <= RST_LOST_CMD;
            r_cfg.trail1    <= RST_TRAIL1;
            r_cfg.trail2    <= RST_TRAIL2;
            r_timeout       <= RST_TIMEOUT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_HEADER:    r_cfg.header    <= i_cfg_data[BYTE_W-1:0];
                REG_FOUND_CMD: r_cfg.found_cmd <= i_cfg_data[BYTE_W-1:0];
                REG_LOST_CMD:  r_cfg.lost_cmd  <= i_cfg_data[BYTE_W-1:0];
                REG_TRAIL1:    r_cfg.trail1    <= i_cfg_data[BYTE_W-1:0];
                REG_TRAIL2:    r_cfg.trail2    <= i_cfg_data[BYTE_W-1:0];
                REG_TIMEOUT:   r_timeout       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    ftpp_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (byte_valid),
        .i_byte       (i_in_data.rx_byte),
        .i_cfg        (r_cfg),
        .o_evt        (evt)
    );

    // Found flag, coordinates and age for the request being accepted.
    always_comb begin
        n_found = r_found;
        n_x     = r_x;
        n_y     = r_y;
        n_age   = r_age;
        expired = 1'b0;
        if (in_fire) begin
            if (i_in_data.mode == MODE_TICK) begin
                if (r_age != AGE_MAX) begin
                    n_age = r_age + AGE_W'(1);
                end
                if (r_found && (n_age > {1'b0, r_timeout})) begin
                    n_found = 1'b0;
                    expired = 1'b1;
                end
            end else if (evt.found_done) begin
                n_x     = evt.x;
                n_y     = evt.y;
                n_found = 1'b1;
                n_age   = '0;
            end else if (evt.lost_done) begin
                n_found = 1'b0;
                n_age   = '0;
            end
        end
        result.target_found = n_found;
        result.target_x     = n_x;
        result.target_y     = n_y;
        result.frame_done   = evt.found_done || evt.lost_done;
        result.timed_out    = expired;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_x     <= '0;
            r_y     <= '0;
            r_age   <= '0;
        end else begin
            r_found <= n_found;
            r_x     <= n_x;
            r_y     <= n_y;
            r_age   <= n_age;
        end
    end

    // Result buffer: output register with a one-entry skid behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || in_fire;
            r_skid_valid <= 1'b0;
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : result;
        end else if (in_fire) begin
            r_skid <= result;
        end
    end

    // A request is either a byte or a tick, so both flags never appear together.
    a_done_xor_timeout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.frame_done && o_out_data.timed_out))
        else $error("frame_done and timed_out in one result");

    // A timeout always leaves the flag cleared.
    a_timeout_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.timed_out) |-> !o_out_data.target_found)
        else $error("timeout result still reports found");

    // The skid register only fills behind a full output register.
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a result while output register is empty");

    // A found frame restarts the age counter.
    a_age_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && evt.found_done) |=> r_age == '0)
        else $error("age not restarted by a found frame");

endmodule

// ===== sim/frame_tracker_pkg.sv =====
// Scoreboard for the framed target packet parser test: a cycle-free model of the
// frame parser, found flag and age counter, plus the queue of predicted results.
// Depends on ftpp_pkg for the request and result structs and register indexes.
package frame_tracker_pkg;
    import ftpp_pkg::*;

    class frame_tracker;
        // Register copies.
        t_frame_cfg            frame_cfg;
        logic [CFG_DATA_W-1:0] timeout;

        // Parser and tracking state.
        t_phase                phase;
        logic [BYTE_W-1:0]     held_cmd;
        logic [BYTE_W-1:0]     payload[PAYLOAD_LEN];
        logic [2:0]            payload_cnt;
        logic [COORD_W-1:0]    coord_x;
        logic [COORD_W-1:0]    coord_y;
        logic                  found;
        logic [AGE_W-1:0]      age;

        t_out                  pending_results[$];
        int unsigned           fail_count;

        function new();
            frame_cfg.header    = RST_HEADER;
            frame_cfg.found_cmd = RST_FOUND_CMD;
            frame_cfg.lost_cmd  = RST_LOST_CMD;
            frame_cfg.trail1    = RST_TRAIL1;
            frame_cfg.trail2    = RST_TRAIL2;
            timeout             = RST_TIMEOUT;
            phase               = PH_HEADER;
            held_cmd            = '0;
            foreach (payload[i]) payload[i] = '0;
            payload_cnt         = '0;
            coord_x             = '0;
            coord_y             = '0;
            found               = 1'b0;
            age                 = '0;
            fail_count          = 0;
        endfunction

        // Mirror a register write; unknown indexes are ignored like the block does.
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_HEADER:    frame_cfg.header    = data[BYTE_W-1:0];
                REG_FOUND_CMD: frame_cfg.found_cmd = data[BYTE_W-1:0];
                REG_LOST_CMD:  frame_cfg.lost_cmd  = data[BYTE_W-1:0];
                REG_TRAIL1:    frame_cfg.trail1    = data[BYTE_W-1:0];
                REG_TRAIL2:    frame_cfg.trail2    = data[BYTE_W-1:0];
                REG_TIMEOUT:   timeout             = data;
                default: ;
            endcase
        endfunction

        // Advance the frame parser by one byte; returns 1 when a frame completes.
        function bit take_byte(logic [BYTE_W-1:0] b);
            bit done;
            done = 1'b0;
            case (phase)
                PH_COMMAND: begin
                    held_cmd = b;
                    if (b == frame_cfg.found_cmd) begin
                        payload_cnt = '0;
                        phase       = PH_PAYLOAD;
                    end else if (b == frame_cfg.lost_cmd) begin
                        phase = PH_TRAIL1;
                    end else begin
                        phase = PH_HEADER;
                    end
                end
                PH_PAYLOAD: begin
                    payload[payload_cnt[1:0]] = b;
                    payload_cnt = payload_cnt + 3'd1;
                    if (payload_cnt >= PAYLOAD_LEN) phase = PH_TRAIL1;
                end
                PH_TRAIL1: begin
                    phase = (b == frame_cfg.trail1) ? PH_TRAIL2 : PH_HEADER;
                end
                PH_TRAIL2: begin
                    // The held command is judged against the registers as they are now.
                    if (b == frame_cfg.trail2) begin
                        if (held_cmd == frame_cfg.found_cmd) begin
                            coord_x = {payload[1], payload[0]};
                            coord_y = {payload[3], payload[2]};
                            found   = 1'b1;
                            age     = '0;
                            done    = 1'b1;
                        end else if (held_cmd == frame_cfg.lost_cmd) begin
                            found = 1'b0;
                            age   = '0;
                            done  = 1'b1;
                        end
                    end
                    phase = PH_HEADER;
                end
                default: begin
                    phase = (b == frame_cfg.header) ? PH_COMMAND : PH_HEADER;
                end
            endcase
            return done;
        endfunction

        // Predict the result of one accepted request and queue it.
        function void note_request(t_in req);
            t_out res;
            res = '0;
            if (req.mode == MODE_BYTE) begin
                res.frame_done = take_byte(req.rx_byte);
            end else begin
                // Ticks age the counter (saturating) and never touch the parser.
                if (age != '1) age = age + 1'b1;
                if (found && age > {1'b0, timeout}) begin
                    found         = 1'b0;
                    res.timed_out = 1'b1;
                end
            end
            res.target_found = found;
            res.target_x     = coord_x;
            res.target_y     = coord_y;
            pending_results.push_back(res);
        endfunction

        // Compare one accepted result with the oldest prediction.
        function void check_result(t_out got);
            t_out want;
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: found=%0d x=%h y=%h done=%0d tmo=%0d",
                             got.target_found, got.target_x, got.target_y,
                             got.frame_done, got.timed_out);
                return;
            end
            want = pending_results.pop_front();
            if (got.target_found !== want.target_found || got.target_x !== want.target_x ||
                got.target_y !== want.target_y || got.frame_done !== want.frame_done ||
                got.timed_out !== want.timed_out) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("mismatch: expected found=%0d x=%h y=%h done=%0d tmo=%0d",
                             want.target_found, want.target_x, want.target_y,
                             want.frame_done, want.timed_out);
                    $display("          got      found=%0d x=%h y=%h done=%0d tmo=%0d",
                             got.target_found, got.target_x, got.target_y,
                             got.frame_done, got.timed_out);
                end
            end
        endfunction

        function int unsigned outstanding();
            return pending_results.size();
        endfunction

        // Any prediction still waiting at the end is a failure.
        function void close_out();
            if (pending_results.size() != 0) begin
                $display("%0d predicted results never arrived", pending_results.size());
                fail_count += pending_results.size();
            end
        endfunction
    endclass

endpackage

// ===== sim/framed_target_packet_parser_test.sv =====
// Top-level test of framed_target_packet_parser: directed frames, register changes
// mid frame, timeouts and random framed traffic checked against frame_tracker.
// Depends on ftpp_pkg, frame_tracker_pkg and the parser RTL.
module framed_target_packet_parser_test;
    import ftpp_pkg::*;
    import frame_tracker_pkg::*;

    typedef logic [BYTE_W-1:0] t_byte_q[$];

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in                   i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out                  o_out_data;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    frame_tracker sb;
    int unsigned  n_sent;
    bit           quiet;
    bit           long_hold_req;

    framed_target_packet_parser u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock with a period of two time units.
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Offer one request at a falling edge and hold it until it is taken.
    task automatic send_request(input t_in req);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(req);
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        t_in req;
        req.mode    = MODE_BYTE;
        req.rx_byte = b;
        send_request(req);
    endtask

    // The byte field of a tick is don't-care, so it carries random bits.
    task automatic send_tick();
        t_in req;
        req.mode    = MODE_TICK;
        req.rx_byte = BYTE_W'($urandom);
        send_request(req);
    endtask

    task automatic send_bytes(input t_byte_q seq);
        foreach (seq[i]) send_byte(seq[i]);
    endtask

    // Register writes happen only while the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Stop offering and wait until every predicted result has come back.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_all(input logic [BYTE_W-1:0] hdr, input logic [BYTE_W-1:0] fcmd,
                             input logic [BYTE_W-1:0] lcmd, input logic [BYTE_W-1:0] t1,
                             input logic [BYTE_W-1:0] t2, input logic [CFG_DATA_W-1:0] tmo);
        write_reg(REG_HEADER, CFG_DATA_W'(hdr));
        write_reg(REG_FOUND_CMD, CFG_DATA_W'(fcmd));
        write_reg(REG_LOST_CMD, CFG_DATA_W'(lcmd));
        write_reg(REG_TRAIL1, CFG_DATA_W'(t1));
        write_reg(REG_TRAIL2, CFG_DATA_W'(t2));
        write_reg(REG_TIMEOUT, tmo);
    endtask

    // Random frame bytes; lost sometimes equals found to hit the shared-command path.
    task automatic randomize_regs();
        logic [BYTE_W-1:0]     fcmd;
        logic [BYTE_W-1:0]     lcmd;
        logic [CFG_DATA_W-1:0] tmo;
        fcmd = BYTE_W'($urandom);
        lcmd = ($urandom_range(0, 3) == 0) ? fcmd : BYTE_W'($urandom);
        tmo  = ($urandom_range(0, 3) == 0) ? '0 : CFG_DATA_W'($urandom_range(1, 24));
        write_all(BYTE_W'($urandom), fcmd, lcmd, BYTE_W'($urandom), BYTE_W'($urandom), tmo);
    endtask

    // Mostly well-formed frames with random payload, the rest broken frames and noise.
    task automatic random_frame();
        t_byte_q     seq;
        int unsigned kind;
        int unsigned cut;
        kind = $urandom_range(0, 99);
        if (kind < 90) begin
            seq.push_back(sb.frame_cfg.header);
            if ($urandom_range(0, 3) == 0) begin
                seq.push_back(sb.frame_cfg.lost_cmd);
            end else begin
                seq.push_back(sb.frame_cfg.found_cmd);
                repeat (PAYLOAD_LEN) seq.push_back(BYTE_W'($urandom));
            end
            seq.push_back(sb.frame_cfg.trail1);
            seq.push_back(sb.frame_cfg.trail2);
            // Break the frame at a structural byte or cut it short.
            if (kind >= 75) begin
                if ($urandom_range(0, 1) == 1) begin
                    case ($urandom_range(0, 3))
                        0:       seq[0] = BYTE_W'($urandom);
                        1:       seq[1] = BYTE_W'($urandom);
                        2:       seq[seq.size() - 2] = BYTE_W'($urandom);
                        default: seq[seq.size() - 1] = BYTE_W'($urandom);
                    endcase
                end else begin
                    cut = $urandom_range(1, seq.size() - 1);
                    repeat (cut) void'(seq.pop_back());
                end
            end
        end else begin
            repeat ($urandom_range(1, 4)) seq.push_back(BYTE_W'($urandom));
        end
        foreach (seq[i]) begin
            if ($urandom_range(0, 7) == 0) send_tick();
            send_byte(seq[i]);
        end
        if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 10)) send_tick();
    endtask

    task automatic run_random(input int unsigned n_items);
        int unsigned start;
        start = n_sent;
        while (n_sent - start < n_items) random_frame();
    endtask

    // Result monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_data);
    end

    // Receiver: short random stalls, and one long hold-off on request.
    initial begin
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (50) @(negedge i_clk);
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                @(negedge i_clk);
            end
        end
    end

    // Watchdog.
    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Main sequence.
    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        quiet         = 1'b0;
        long_hold_req = 1'b0;
        n_sent        = 0;
        sb            = new();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed frames at reset register values.
        send_bytes('{8'hAA, 8'h01, 8'h34, 8'h12, 8'h78, 8'h56, 8'h0D, 8'h0A});
        send_tick();
        send_bytes('{8'hAA, 8'h00, 8'h0D, 8'h0A});
        // Bad first trailer after a full payload, bad command, bad second trailer, bad header.
        send_bytes('{8'hAA, 8'h01, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h0E});
        send_bytes('{8'hAA, 8'h07});
        send_bytes('{8'hAA, 8'h00, 8'h0D, 8'h0B});
        send_byte(8'h55);
        settle();

        // Lost frame whose command becomes the found command before the last trailer.
        send_bytes('{8'hAA, 8'h00, 8'h0D});
        settle();
        write_reg(REG_FOUND_CMD, CFG_DATA_W'(8'h00));
        send_byte(8'h0A);
        settle();
        write_reg(REG_FOUND_CMD, CFG_DATA_W'(RST_FOUND_CMD));
        // Lost frame whose command matches neither register at the last trailer.
        send_bytes('{8'hAA, 8'h00, 8'h0D});
        settle();
        write_reg(REG_LOST_CMD, CFG_DATA_W'(8'h05));
        send_byte(8'h0A);
        settle();
        write_reg(REG_LOST_CMD, CFG_DATA_W'(RST_LOST_CMD));

        // Low extremes with zero timeout; the receiver holds off long here.
        write_all(8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, '0);
        long_hold_req = 1'b1;
        run_random(105);
        settle();

        // High extremes, shared command, largest timeout.
        write_all(8'hFF, 8'h5A, 8'h5A, 8'hFF, 8'h00, '1);
        run_random(105);
        settle();

        // Found must survive exactly the timeout and clear on the tick after.
        write_reg(REG_TIMEOUT, CFG_DATA_W'(16));
        quiet = 1'b1;
        send_bytes('{8'hFF, 8'h5A, 8'h11, 8'h22, 8'h33, 8'h44, 8'hFF, 8'h00});
        repeat (17) send_tick();
        settle();
        quiet = 1'b0;

        repeat (6) begin
            randomize_regs();
            run_random(105);
            settle();
        end

        // Last stretch at reset frame bytes, a timeout of 5 and no idling.
        write_all(RST_HEADER, RST_FOUND_CMD, RST_LOST_CMD, RST_TRAIL1, RST_TRAIL2,
                  RST_TIMEOUT);
        write_reg(REG_TIMEOUT, CFG_DATA_W'(5));
        quiet = 1'b1;
        run_random(105);
        settle();
        repeat (4) @(negedge i_clk);

        sb.close_out();
        if (sb.fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
